FILE: design/bcd_time_of_day_setter_assert.svh
// Assertion macros shared by the time setter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BCD_TIME_OF_DAY_SETTER_ASSERT_SVH
`define BCD_TIME_OF_DAY_SETTER_ASSERT_SVH

// Property that must hold in the same cycle.
`define BCDT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next cycle.
`define BCDT_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/bcdt_pkg.sv
// Types and codes for the BCD time-of-day setter.
// Has no dependencies; used by every module of the block.
package bcdt_pkg;

  typedef enum logic [3:0] {
    CMD_HT_UP  = 4'd0,
    CMD_HT_DN  = 4'd1,
    CMD_HU_UP  = 4'd2,
    CMD_HU_DN  = 4'd3,
    CMD_MT_UP  = 4'd4,
    CMD_MT_DN  = 4'd5,
    CMD_MU_UP  = 4'd6,
    CMD_MU_DN  = 4'd7,
    CMD_OK     = 4'd8,
    CMD_CANCEL = 4'd9,
    CMD_LOAD   = 4'd10,
    CMD_CLEAR  = 4'd11,
    CMD_REOPEN = 4'd12
  } cmd_e;

  typedef enum logic [1:0] {
    ST_EDIT   = 2'd0,
    ST_OK     = 2'd1,
    ST_CANCEL = 2'd2
  } status_e;

  localparam logic [4:0] MaxHour   = 5'd23;
  localparam logic [5:0] MaxMinute = 6'd59;

  typedef struct packed {
    logic [3:0] cmd;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
  } in_item_t;

  typedef struct packed {
    logic [1:0] hour_tens_digit;
    logic [3:0] hour_units_digit;
    logic [2:0] minute_tens_digit;
    logic [3:0] minute_units_digit;
    logic [4:0] hours_binary;
    logic [5:0] minutes_binary;
    logic [1:0] entry_status;
  } out_item_t;

  typedef struct packed {
    logic [1:0] ht;
    logic [3:0] hu;
    logic [2:0] mt;
    logic [3:0] mu;
  } time_t;

endpackage

FILE: design/bcdt_in_stage.sv
// Input register of the time setter: holds one accepted command.
// Depends on bcdt_pkg for the input item type.
module bcdt_in_stage import bcdt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic     advance_i,
  output logic     item_valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t data_q;

  assign in_stall_o   = valid_q && !advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

FILE: design/bcdt_next.sv
// Next time and status for one command: digit steps, load, ok, cancel, clear
// and reopen. Depends on bcdt_pkg for the command codes and the time type.
module bcdt_next import bcdt_pkg::*; (
  input  time_t    cur_time_i,
  input  status_e  cur_status_i,
  input  in_item_t item_i,
  output time_t    next_time_o,
  output status_e  next_status_o
);

  logic       edit;
  logic [1:0] ht;
  logic [3:0] hu;
  logic [2:0] mt;
  logic [3:0] mu;
  logic [1:0] ld_ht;
  logic [4:0] ld_hu;
  logic [2:0] ld_mt;
  logic [5:0] ld_mu;
  logic       ld_ok;

  assign edit = (cur_status_i == ST_EDIT);
  assign ht   = cur_time_i.ht;
  assign hu   = cur_time_i.hu;
  assign mt   = cur_time_i.mt;
  assign mu   = cur_time_i.mu;
  assign ld_ok = (item_i.load_hour <= MaxHour) && (item_i.load_minute <= MaxMinute);

  always_comb begin
    priority if (item_i.load_hour >= 5'd20) begin
      ld_ht = 2'd2;
      ld_hu = item_i.load_hour - 5'd20;
    end else if (item_i.load_hour >= 5'd10) begin
      ld_ht = 2'd1;
      ld_hu = item_i.load_hour - 5'd10;
    end else begin
      ld_ht = 2'd0;
      ld_hu = item_i.load_hour;
    end
  end

  always_comb begin
    priority if (item_i.load_minute >= 6'd50) begin
      ld_mt = 3'd5;
      ld_mu = item_i.load_minute - 6'd50;
    end else if (item_i.load_minute >= 6'd40) begin
      ld_mt = 3'd4;
      ld_mu = item_i.load_minute - 6'd40;
    end else if (item_i.load_minute >= 6'd30) begin
      ld_mt = 3'd3;
      ld_mu = item_i.load_minute - 6'd30;
    end else if (item_i.load_minute >= 6'd20) begin
      ld_mt = 3'd2;
      ld_mu = item_i.load_minute - 6'd20;
    end else if (item_i.load_minute >= 6'd10) begin
      ld_mt = 3'd1;
      ld_mu = item_i.load_minute - 6'd10;
    end else begin
      ld_mt = 3'd0;
      ld_mu = item_i.load_minute;
    end
  end

  always_comb begin
    next_time_o   = cur_time_i;
    next_status_o = cur_status_i;
    unique case (item_i.cmd)
      CMD_HT_UP: begin
        if (edit && (ht < 2'd1 || (ht == 2'd1 && hu < 4'd4))) begin
          next_time_o.ht = ht + 2'd1;
        end
      end
      CMD_HT_DN: begin
        if (edit && ht != 2'd0) begin
          next_time_o.ht = ht - 2'd1;
        end
      end
      CMD_HU_UP: begin
        if (edit) begin
          if (hu < 4'd9) begin
            if (ht < 2'd2 || hu < 4'd3) begin
              next_time_o.hu = hu + 4'd1;
            end else begin
              next_time_o.hu = 4'd0;
              next_time_o.ht = 2'd0;
            end
          end else begin
            if (ht < 2'd2) begin
              next_time_o.ht = ht + 2'd1;
            end
            next_time_o.hu = 4'd0;
          end
        end
      end
      CMD_HU_DN: begin
        if (edit) begin
          if (hu != 4'd0) begin
            next_time_o.hu = hu - 4'd1;
          end else if (ht != 2'd0) begin
            next_time_o.ht = ht - 2'd1;
            next_time_o.hu = 4'd9;
          end else begin
            next_time_o.ht = 2'd2;
            next_time_o.hu = 4'd3;
          end
        end
      end
      CMD_MT_UP: begin
        if (edit && mt < 3'd5) begin
          next_time_o.mt = mt + 3'd1;
        end
      end
      CMD_MT_DN: begin
        if (edit && mt != 3'd0) begin
          next_time_o.mt = mt - 3'd1;
        end
      end
      CMD_MU_UP: begin
        if (edit) begin
          if (mu < 4'd9) begin
            next_time_o.mu = mu + 4'd1;
          end else if (mt < 3'd5) begin
            next_time_o.mt = mt + 3'd1;
            next_time_o.mu = 4'd0;
          end else begin
            next_time_o.mt = 3'd0;
            next_time_o.mu = 4'd0;
          end
        end
      end
      CMD_MU_DN: begin
        if (edit) begin
          if (mu != 4'd0) begin
            next_time_o.mu = mu - 4'd1;
          end else if (mt != 3'd0) begin
            next_time_o.mt = mt - 3'd1;
            next_time_o.mu = 4'd9;
          end else begin
            next_time_o.mt = 3'd5;
            next_time_o.mu = 4'd9;
          end
        end
      end
      CMD_OK: begin
        if (edit) begin
          next_status_o = ST_OK;
        end
      end
      CMD_CANCEL: begin
        if (edit) begin
          next_status_o = ST_CANCEL;
        end
      end
      CMD_LOAD: begin
        if (ld_ok) begin
          next_time_o.ht = ld_ht;
          next_time_o.hu = ld_hu[3:0];
          next_time_o.mt = ld_mt;
          next_time_o.mu = ld_mu[3:0];
        end
      end
      CMD_CLEAR: begin
        next_status_o = ST_EDIT;
      end
      CMD_REOPEN: begin
        next_time_o   = '0;
        next_status_o = ST_EDIT;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/bcd_time_of_day_setter.sv
// BCD time-of-day setter. Each command transfer steps, loads, confirms,
// cancels, clears or reopens a 24-hour time kept as four BCD digits and
// returns one result transfer with the digits, the binary hour and minute,
// and the entry status. One command is taken every clock cycle unless the
// output stalls; its result passes through the input register, then the
// time and result registers, which update together. Depends on bcdt_pkg,
// bcdt_in_stage, bcdt_next and the assertion macro header.
`include "bcd_time_of_day_setter_assert.svh"

module bcd_time_of_day_setter import bcdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      item_valid;
  in_item_t  item;
  logic      advance;
  time_t     time_q;
  time_t     time_d;
  status_e   status_q;
  status_e   status_d;
  logic      out_valid_q;
  out_item_t out_data_q;
  out_item_t out_data_d;

  assign advance = item_valid && (!out_valid_q || !out_stall_i);

  bcdt_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  bcdt_next u_next (
    .cur_time_i    (time_q),
    .cur_status_i  (status_q),
    .item_i        (item),
    .next_time_o   (time_d),
    .next_status_o (status_d)
  );

  always_comb begin
    out_data_d.hour_tens_digit    = time_d.ht;
    out_data_d.hour_units_digit   = time_d.hu;
    out_data_d.minute_tens_digit  = time_d.mt;
    out_data_d.minute_units_digit = time_d.mu;
    out_data_d.hours_binary       = ({3'b0, time_d.ht} << 3) + ({3'b0, time_d.ht} << 1)
                                    + {1'b0, time_d.hu};
    out_data_d.minutes_binary     = ({3'b0, time_d.mt} << 3) + ({3'b0, time_d.mt} << 1)
                                    + {2'b0, time_d.mu};
    out_data_d.entry_status       = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      status_q    <= ST_EDIT;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        time_q   <= time_d;
        status_q <= status_d;
      end
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= item_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BCDT_ASSERT(a_digits_range, clk_i, rst_ni, time_q.ht <= 2'd2 && time_q.hu <= 4'd9 && time_q.mt <= 3'd5 && time_q.mu <= 4'd9, "time digit out of range")
  `BCDT_ASSERT(a_out_binary, clk_i, rst_ni, !out_valid_o || (out_data_o.hours_binary <= MaxHour && out_data_o.minutes_binary <= MaxMinute), "binary time out of range")
  `BCDT_ASSERT_NEXT(a_reopen, clk_i, rst_ni, advance && item.cmd == CMD_REOPEN, time_q == '0 && status_q == ST_EDIT, "reopen did not clear the entry")
  `BCDT_ASSERT_NEXT(a_ok_closed, clk_i, rst_ni, advance && item.cmd == CMD_OK && status_q != ST_EDIT, $stable(status_q), "ok changed a finished entry")

endmodule
